// ===== rtl/npr_pkg.sv =====
`default_nettype none

package npr_pkg;

  localparam int SAMPLE_WIDTH  = 18;
  localparam int CORDIC_STAGES = 16;

  localparam int FRAC_BITS  = SAMPLE_WIDTH - 3;
  localparam int GUARD_BITS = 16;
  // rotator datapath: sample plus guard bits plus CORDIC growth and sign
  localparam int XW = SAMPLE_WIDTH + GUARD_BITS + 3;
  // phase word, signed Q.32, always within +/- 2*pi
  localparam int AW = 36;
  localparam int IW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  // stages of the phase front end
  localparam int PH_STAGES = 10;

  // power scaling of p onto Q.24
  localparam int unsigned P_SHR = (2 * FRAC_BITS >= 24) ? 2 * FRAC_BITS - 24 : 0;
  localparam int unsigned P_SHL = (2 * FRAC_BITS >= 24) ? 0 : 24 - 2 * FRAC_BITS;

  localparam logic [31:0] STEP_GAIN_RESET = 32'd429;

  localparam logic [34:0] TWO_PI_U = 35'd26986075409;
  localparam logic [34:0] PI_U     = 35'd13493037705;
  localparam logic signed [AW-1:0] PI_S      = 36'sd13493037705;
  localparam logic signed [AW-1:0] HALF_PI_S = 36'sd6746518852;
  localparam logic signed [AW-1:0] NEG_HALF_PI_S = -36'sd6746518852;
  localparam logic signed [33:0] GAIN_S = 34'sd2608131496;

  // floor(2^50 / (2*pi in Q.32)): reciprocal for the modulo estimate
  localparam logic [63:0] RECIP_FULL = (64'd1 << 50) / 64'd26986075409;
  localparam logic [15:0] RECIP_Q50  = RECIP_FULL[15:0];

  typedef logic signed [SAMPLE_WIDTH-1:0] npr_sample_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] ang;
    logic                 last;
  } npr_rot_t;

  typedef struct packed {
    logic     valid;
    npr_rot_t rot;
  } npr_link_t;

  // Q.32 elementary angle atan(2^-i), rounded; past i = 10 it is 2^(32-i)
  function automatic logic signed [AW-1:0] npr_stage_angle(input logic [IW-1:0] idx);
    int k;
    logic signed [AW-1:0] a;
    k = int'(idx);
    unique case (k)
      0:       a = 36'sd3373259426;
      1:       a = 36'sd1991351318;
      2:       a = 36'sd1052175346;
      3:       a = 36'sd534100635;
      4:       a = 36'sd268086748;
      5:       a = 36'sd134174063;
      6:       a = 36'sd67103403;
      7:       a = 36'sd33553749;
      8:       a = 36'sd16777131;
      9:       a = 36'sd8388597;
      10:      a = 36'sd4194303;
      default: a = AW'(64'd1 << (32 - k));
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nonlinear_phase_rotator_top.sv =====
`default_nettype none

// Nonlinear phase rotator: applies one cubic-quintic split-step phase to a
// stream of complex Q2.15 samples. Each word is rotated by
// theta = (p - p^2) * dt with p = re^2 + im^2 and dt = cfg_step_gain * 2^-32
// (reset value 429); theta is reduced modulo 2*pi, folded into +/- pi/2 and
// applied by a chain of CORDIC cells, then rounded and saturated back to
// Q2.15. The frame-end flag rides along with its sample. Throughput is one
// word per clock while the output side takes words. The pipe holds ten
// front-end stages that form and reduce the phase and scale the sample by
// the CORDIC gain, one cell per CORDIC iteration, and one output register.
// Every stage holds its own valid bit and empty stages collapse, so
// in_ready drops only when every stage is full and the output word is not
// being taken. cfg_ready is always high; write the step gain only while no
// word is in flight.
module nonlinear_phase_rotator_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire npr_pkg::npr_sample_t in_re_in,
  input  wire npr_pkg::npr_sample_t in_im_in,
  input  wire logic                 in_frame_last_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output npr_pkg::npr_sample_t      out_re_out,
  output npr_pkg::npr_sample_t      out_im_out,
  output logic                      out_frame_last_out,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [31:0]          cfg_step_gain
);

  localparam int W  = npr_pkg::SAMPLE_WIDTH;
  localparam int XW = npr_pkg::XW;
  localparam int NC = npr_pkg::CORDIC_STAGES;
  localparam logic signed [XW:0] SAT_HI = (XW+1)'((64'sd1 <<< (W-1)) - 64'sd1);
  localparam logic signed [XW:0] SAT_LO = -SAT_HI - (XW+1)'(1);
  localparam logic signed [XW:0] HALF_LSB = (XW+1)'(64'sd1 <<< (npr_pkg::GUARD_BITS-1));

  logic [31:0] step_gain_r;

  npr_pkg::npr_link_t cl [0:NC];
  logic               take [0:NC];

  logic                 out_valid_r;
  npr_pkg::npr_sample_t out_re_r, out_im_r;
  logic                 out_last_r;
  npr_pkg::npr_sample_t re_nxt, im_nxt;

  // round to nearest (half up), then clamp to the Q2.15 range
  function automatic npr_pkg::npr_sample_t npr_finish(input logic signed [XW-1:0] v);
    logic signed [XW:0] t;
    logic signed [XW:0] r;
    npr_pkg::npr_sample_t s;
    t = (XW+1)'(v) + HALF_LSB;
    r = t >>> npr_pkg::GUARD_BITS;
    priority if (r < SAT_LO) begin
      s = SAT_LO[W-1:0];
    end else if (r > SAT_HI) begin
      s = SAT_HI[W-1:0];
    end else begin
      s = r[W-1:0];
    end
    return s;
  endfunction

  // step gain register: always ready, write on valid
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_gain_r <= npr_pkg::STEP_GAIN_RESET;
    end else if (cfg_valid) begin
      step_gain_r <= cfg_step_gain;
    end
  end

  // phase front end: power, phase, modulo 2*pi, fold, gain scaling
  npr_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_gain (step_gain_r),
    .up_valid  (in_valid),
    .up_take   (in_ready),
    .up_re     (in_re_in),
    .up_im     (in_im_in),
    .up_last   (in_frame_last_in),
    .dn        (cl[0]),
    .dn_take   (take[0])
  );

  // CORDIC chain: each cell does one iteration and hands its word on
  for (genvar i = 0; i < NC; i++) begin : g_cell
    npr_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (npr_pkg::IW'(i)),
      .up        (cl[i]),
      .up_take   (take[i]),
      .dn        (cl[i+1]),
      .dn_take   (take[i+1])
    );
  end

  // output register: advance when empty or when the word is taken
  assign take[NC] = !out_valid_r || out_ready;

  always_comb begin
    re_nxt = npr_finish(cl[NC].rot.x);
    im_nxt = npr_finish(cl[NC].rot.y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take[NC]) begin
      out_valid_r <= cl[NC].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take[NC]) begin
      out_re_r   <= re_nxt;
      out_im_r   <= im_nxt;
      out_last_r <= cl[NC].rot.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_re_out         = out_re_r;
  assign out_im_out         = out_im_r;
  assign out_frame_last_out = out_last_r;

`ifndef NO_ASSERTIONS
  // input stalls only when the whole pipe is full behind a held output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output side can drain");

  // folded phase entering the CORDIC lies within +/- pi/2
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    cl[0].valid |-> (cl[0].rot.ang <= npr_pkg::HALF_PI_S &&
                     cl[0].rot.ang >= npr_pkg::NEG_HALF_PI_S))
    else $error("phase not folded into +/- pi/2");

  // a new output word must come from a valid last CORDIC cell
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cl[NC].valid))
    else $error("output word appeared without a source");
`endif

endmodule

`default_nettype wire

// ===== rtl/npr_phase.sv =====
`default_nettype none

module npr_phase (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [31:0]          step_gain,
  input  wire logic                 up_valid,
  output logic                      up_take,
  input  wire npr_pkg::npr_sample_t up_re,
  input  wire npr_pkg::npr_sample_t up_im,
  input  wire logic                 up_last,
  output npr_pkg::npr_link_t        dn,
  input  wire logic                 dn_take
);

  localparam int W  = npr_pkg::SAMPLE_WIDTH;
  localparam int NS = npr_pkg::PH_STAGES;
  localparam int LD = NS - 2;

  logic [NS-1:0] v_r;
  logic [NS:0]   adv;

  // sample delay line, consumed by the gain stage
  npr_pkg::npr_sample_t re_d_r [0:LD];
  npr_pkg::npr_sample_t im_d_r [0:LD];
  logic                 last_d_r [0:LD];
  logic                 neg_d_r [2:LD];

  logic [2*W-1:0]        p0_r;
  logic [59:0]           quad1_r;
  logic [29:0]           p24_1_r;
  logic [27:0]           m16_2_r;
  logic [43:0]           mag32_3_r;
  logic [43:0]           mag32_4_r;
  logic [9:0]            qe4_r;
  logic [35:0]           rem5_r;
  logic [34:0]           r6_r;
  logic signed [35:0]    a7_r;
  logic signed [35:0]    b8_r;
  logic                  flip8_r;
  npr_pkg::npr_rot_t     rot9_r;

  logic [W-1:0]          ar, ai;
  logic [2*W-1:0]        ar_w, ai_w, p_nxt;
  logic [29:0]           p24;
  logic [59:0]           quad_nxt, lin, mag;
  logic                  neg_nxt;
  logic [59:0]           gprod;
  logic [13:0]           hi;
  logic [29:0]           qprod;
  logic [44:0]           qt, rem;
  logic [34:0]           r1_nxt;
  logic signed [35:0]    a_nxt, b_nxt;
  logic                  flip_nxt;
  logic signed [W:0]     sre, sim;
  logic signed [W+33:0]  xp, yp;
  npr_pkg::npr_rot_t     rot_nxt;

  // stage k moves when any stage at or after it is empty, or the chain drains
  always_comb begin
    adv[NS] = dn_take;
    for (int k = 0; k < NS; k++) begin
      adv[k] = adv[NS] || (|(~v_r >> k));
    end
  end

  assign up_take   = adv[0];
  assign dn.valid  = v_r[NS-1];
  assign dn.rot    = rot9_r;

  always_comb begin
    ar = up_re[W-1] ? W'(-up_re) : W'(up_re);
    ai = up_im[W-1] ? W'(-up_im) : W'(up_im);
    ar_w = {{W{1'b0}}, ar};
    ai_w = {{W{1'b0}}, ai};
    p_nxt = ar_w * ar_w + ai_w * ai_w;

    p24 = 30'(({30'd0, p0_r} >> npr_pkg::P_SHR) << npr_pkg::P_SHL);
    quad_nxt = 60'(p24) * 60'(p24);

    lin = {6'd0, p24_1_r, 24'd0};
    neg_nxt = quad1_r > lin;
    mag = neg_nxt ? quad1_r - lin : lin - quad1_r;

    gprod = 60'(m16_2_r) * 60'(step_gain);

    hi = mag32_3_r[43:30];
    qprod = 30'(hi) * 30'(npr_pkg::RECIP_Q50);

    qt  = 45'(qe4_r) * 45'(npr_pkg::TWO_PI_U);
    rem = 45'(mag32_4_r) - qt;

    r1_nxt = (rem5_r >= 36'(npr_pkg::TWO_PI_U)) ?
             35'(rem5_r - 36'(npr_pkg::TWO_PI_U)) : rem5_r[34:0];

    a_nxt = (r6_r > npr_pkg::PI_U) ?
            signed'(36'(r6_r) - 36'(npr_pkg::TWO_PI_U)) : signed'(36'(r6_r));

    // fold into +/- pi/2; the sample takes the half turn
    priority if (a7_r > npr_pkg::HALF_PI_S) begin
      b_nxt = a7_r - npr_pkg::PI_S;
      flip_nxt = 1'b1;
    end else if (a7_r < npr_pkg::NEG_HALF_PI_S) begin
      b_nxt = a7_r + npr_pkg::PI_S;
      flip_nxt = 1'b1;
    end else begin
      b_nxt = a7_r;
      flip_nxt = 1'b0;
    end

    sre = flip8_r ? -((W+1)'(re_d_r[LD])) : (W+1)'(re_d_r[LD]);
    sim = flip8_r ? -((W+1)'(im_d_r[LD])) : (W+1)'(im_d_r[LD]);
    xp = sre * npr_pkg::GAIN_S;
    yp = sim * npr_pkg::GAIN_S;
    rot_nxt.x    = npr_pkg::XW'(xp >>> npr_pkg::GUARD_BITS);
    rot_nxt.y    = npr_pkg::XW'(yp >>> npr_pkg::GUARD_BITS);
    rot_nxt.ang  = neg_d_r[LD] ? -b8_r : b8_r;
    rot_nxt.last = last_d_r[LD];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      re_d_r[0]   <= up_re;
      im_d_r[0]   <= up_im;
      last_d_r[0] <= up_last;
      p0_r        <= p_nxt;
    end
    for (int k = 1; k <= LD; k++) begin
      if (adv[k]) begin
        re_d_r[k]   <= re_d_r[k-1];
        im_d_r[k]   <= im_d_r[k-1];
        last_d_r[k] <= last_d_r[k-1];
      end
    end
    if (adv[1]) begin
      quad1_r <= quad_nxt;
      p24_1_r <= p24;
    end
    if (adv[2]) begin
      neg_d_r[2] <= neg_nxt;
      m16_2_r    <= mag[59:32];
    end
    for (int k = 3; k <= LD; k++) begin
      if (adv[k]) begin
        neg_d_r[k] <= neg_d_r[k-1];
      end
    end
    if (adv[3]) begin
      mag32_3_r <= gprod[59:16];
    end
    if (adv[4]) begin
      mag32_4_r <= mag32_3_r;
      qe4_r     <= qprod[29:20];
    end
    if (adv[5]) begin
      rem5_r <= rem[35:0];
    end
    if (adv[6]) begin
      r6_r <= r1_nxt;
    end
    if (adv[7]) begin
      a7_r <= a_nxt;
    end
    if (adv[8]) begin
      b8_r    <= b_nxt;
      flip8_r <= flip_nxt;
    end
    if (adv[9]) begin
      rot9_r <= rot_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/npr_cordic_cell.sv =====
`default_nettype none

module npr_cordic_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [npr_pkg::IW-1:0] stage_idx,
  input  wire npr_pkg::npr_link_t    up,
  output logic                       up_take,
  output npr_pkg::npr_link_t         dn,
  input  wire logic                  dn_take
);

  logic              v_r;
  npr_pkg::npr_rot_t rot_r;
  npr_pkg::npr_rot_t rot_nxt;
  logic signed [npr_pkg::XW-1:0] xs, ys;
  logic signed [npr_pkg::AW-1:0] step_ang;

  assign up_take  = !v_r || dn_take;
  assign dn.valid = v_r;
  assign dn.rot   = rot_r;

  // one micro-rotation toward zero residual angle
  always_comb begin
    xs = up.rot.x >>> stage_idx;
    ys = up.rot.y >>> stage_idx;
    step_ang = npr_pkg::npr_stage_angle(stage_idx);
    rot_nxt.last = up.rot.last;
    if (up.rot.ang >= 0) begin
      rot_nxt.x   = up.rot.x - ys;
      rot_nxt.y   = up.rot.y + xs;
      rot_nxt.ang = up.rot.ang - step_ang;
    end else begin
      rot_nxt.x   = up.rot.x + ys;
      rot_nxt.y   = up.rot.y - xs;
      rot_nxt.ang = up.rot.ang + step_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_take) begin
      v_r <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_take) begin
      rot_r <= rot_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== tb/nonlinear_phase_rotator_top_tb.sv =====
`default_nettype none

module nonlinear_phase_rotator_top_tb;

  import npr_pkg::*;

  localparam int SW        = SAMPLE_WIDTH;
  localparam int FRAC      = SW - 3;
  // p lands on Q.24; a positive shift moves right
  localparam int P_SHIFT   = 2 * FRAC - 24;
  // cycles the receiver holds off to fill the pipe, well past its depth
  localparam int CHOKE_CYCLES = 80;
  // cycles to linger after the last word, a bit past the pipe latency
  localparam int DRAIN_CYCLES = 40;
  localparam int N_PHASES     = 10;
  localparam int PHASE_WORDS  = 143;
  localparam int CHOKE_PHASE  = 3;

  // phase constants in Q.32, gain of an endless CORDIC in Q.32
  localparam longint PI_Q      = 64'sd13493037705;
  localparam longint TWO_PI_Q  = 64'sd26986075409;
  localparam longint HALF_PI_Q = 64'sd6746518852;
  localparam longint CORDIC_K  = 64'sd2608131496;
  // rounded atan(2^-i) in Q.32; later stages use 2^(32-i)
  localparam longint ATAN_Q [0:10] = '{
    64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
    64'sd268086748,  64'sd134174063,  64'sd67103403,   64'sd33553749,
    64'sd16777131,   64'sd8388597,    64'sd4194303
  };

  localparam npr_sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam npr_sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    npr_sample_t re;
    npr_sample_t im;
    logic        last;
  } rot_word_t;

  // one row of the directed sweep; known rows carry a hand-typed answer
  typedef struct packed {
    logic [31:0] gain;
    npr_sample_t re;
    npr_sample_t im;
    logic        last;
    logic        known;
    npr_sample_t k_re;
    npr_sample_t k_im;
  } probe_t;

  localparam int N_PROBES = 20;
  localparam probe_t PROBES [0:N_PROBES-1] = '{
    // reset gain: zero, full-scale corners, unit power, tiny values
    '{32'd429, 18'sd0, 18'sd0, 1'b0, 1'b1, 18'sd0, 18'sd0},
    '{32'd429, S_MAX, S_MAX, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'd429, S_MIN, S_MIN, 1'b1, 1'b0, 18'sd0, 18'sd0},
    '{32'd429, S_MAX, S_MIN, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'd429, S_MIN, S_MAX, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'd429, 18'sd32768, 18'sd0, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'd429, 18'sd1, -18'sd1, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'd429, -18'sd1, 18'sd0, 1'b1, 1'b0, 18'sd0, 18'sd0},
    '{32'd429, 18'sd0, S_MIN, 1'b0, 1'b0, 18'sd0, 18'sd0},
    // zero gain: no phase, only the CORDIC residue
    '{32'd0, S_MAX, 18'sd0, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'd0, S_MIN, S_MIN, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'd0, 18'sd0, 18'sd0, 1'b1, 1'b1, 18'sd0, 18'sd0},
    // full gain: large phases, wrap past pi and fold past pi/2; then a gain of one and half gain
    '{32'hFFFF_FFFF, S_MAX, S_MAX, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'hFFFF_FFFF, S_MIN, S_MAX, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'hFFFF_FFFF, 18'sd46341, 18'sd46341, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'hFFFF_FFFF, 18'sd20000, -18'sd70000, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'hFFFF_FFFF, 18'sd0, 18'sd0, 1'b1, 1'b1, 18'sd0, 18'sd0},
    '{32'd1, S_MAX, -18'sd1, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'h8000_0000, 18'sd100000, 18'sd50000, 1'b0, 1'b0, 18'sd0, 18'sd0},
    '{32'h8000_0000, -18'sd5, 18'sd7, 1'b1, 1'b0, 18'sd0, 18'sd0}
  };

  // every block input starts at a known value
  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  npr_sample_t in_re_in         = '0;
  npr_sample_t in_im_in         = '0;
  logic        in_frame_last_in = 1'b0;
  logic        out_ready        = 1'b0;
  logic        cfg_valid        = 1'b0;
  logic [31:0] cfg_step_gain    = STEP_GAIN_RESET;

  logic        in_ready;
  logic        out_valid;
  npr_sample_t out_re_out;
  npr_sample_t out_im_out;
  logic        out_frame_last_out;
  logic        cfg_ready;

  // expected words in arrival order, and the step gain the block holds
  rot_word_t   rotations_due [$];
  logic [31:0] gain_now = STEP_GAIN_RESET;

  int n_err      = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_settings = 1;

  // pacing flags: calm for both sides, tx_jitter for the sender, choke_req for the receiver
  bit calm      = 1'b0;
  bit tx_jitter = 1'b1;
  bit choke_req = 1'b0;

  nonlinear_phase_rotator_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_re_in          (in_re_in),
    .in_im_in          (in_im_in),
    .in_frame_last_in  (in_frame_last_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_re_out        (out_re_out),
    .out_im_out        (out_im_out),
    .out_frame_last_out(out_frame_last_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_step_gain     (cfg_step_gain)
  );

  always #10 clk = ~clk;

  // Round half up, drop the guard bits, clamp to the sample range.
  function automatic npr_sample_t round_sat(input longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r < longint'(S_MIN)) r = longint'(S_MIN);
    if (r > longint'(S_MAX)) r = longint'(S_MAX);
    return npr_sample_t'(r);
  endfunction

  // Work out the rotated word for one sample under the current step gain.
  function automatic rot_word_t predict_rotation(input npr_sample_t re_s,
                                                 input npr_sample_t im_s,
                                                 input logic last);
    longint re, im, ar, ai, pw, p24, lin, quad, mag, m16, mag32;
    longint ang, x, y, xs, ys, da;
    bit neg;
    rot_word_t w;
    re = re_s;
    im = im_s;
    ar = (re < 0) ? -re : re;
    ai = (im < 0) ? -im : im;
    pw = ar * ar + ai * ai;
    if (P_SHIFT >= 0) p24 = pw >> P_SHIFT;
    else p24 = pw << (-P_SHIFT);
    // p - p^2 as sign and magnitude in Q.48
    lin  = p24 << 24;
    quad = p24 * p24;
    neg  = quad > lin;
    mag  = neg ? quad - lin : lin - quad;
    m16  = mag >> 32;
    mag32 = (m16 * longint'({32'd0, gain_now})) >> 16;
    // wrap into [-pi, pi], then apply the sign
    ang = mag32 % TWO_PI_Q;
    if (ang > PI_Q) ang -= TWO_PI_Q;
    if (neg) ang = -ang;
    // fold past +/- pi/2 by negating the sample
    if (ang > HALF_PI_Q) begin
      ang -= PI_Q;
      re = -re;
      im = -im;
    end else if (ang < -HALF_PI_Q) begin
      ang += PI_Q;
      re = -re;
      im = -im;
    end
    x = (re * CORDIC_K) >>> 16;
    y = (im * CORDIC_K) >>> 16;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (i <= 10) da = ATAN_Q[i];
      else da = 64'sd1 <<< (32 - i);
      if (ang >= 0) begin
        x = x - ys;
        y = y + xs;
        ang -= da;
      end else begin
        x = x + ys;
        y = y - xs;
        ang += da;
      end
    end
    w.re   = round_sat(x);
    w.im   = round_sat(y);
    w.last = last;
    return w;
  endfunction

  // Draw one sample part: full range, small, near unit power, or an extreme.
  function automatic npr_sample_t pick_sample();
    int unsigned mag;
    case ($urandom_range(0, 7))
      0, 1, 2: return npr_sample_t'($urandom);
      3, 4:    mag = $urandom_range(0, 4095);
      5, 6:    mag = $urandom_range(20000, 46341);
      default: begin
        case ($urandom_range(0, 4))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return '0;
          3:       return npr_sample_t'(1);
          default: return '1;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) != 0) return -npr_sample_t'(mag);
    return npr_sample_t'(mag);
  endfunction

  // Offer one word and hold it until taken; log its expected rotation then.
  // Call at a rising edge; returns at the edge that took the word.
  task automatic offer(input npr_sample_t re, input npr_sample_t im, input logic last,
                       input logic known, input npr_sample_t k_re,
                       input npr_sample_t k_im);
    logic rdy;
    int gap;
    rot_word_t w;
    if (!calm && tx_jitter && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_re_in         <= re;
    in_im_in         <= im;
    in_frame_last_in <= last;
    // sample ready mid-cycle so the edge decision never races the block
    forever begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
      if (rdy) break;
    end
    if (known) begin
      w.re   = k_re;
      w.im   = k_im;
      w.last = last;
    end else begin
      w = predict_rotation(re, im, last);
    end
    rotations_due.push_back(w);
    n_sent++;
  endtask

  // Drop valid, wait out every word in flight, then write the step gain.
  task automatic load_step_gain(input logic [31:0] g);
    logic rdy;
    in_valid <= 1'b0;
    while (rotations_due.size() != 0) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_step_gain <= g;
    forever begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
      if (rdy) break;
    end
    cfg_valid <= 1'b0;
    gain_now = g;
    n_settings++;
  endtask

  task automatic check_field(input string what, input npr_sample_t want,
                             input npr_sample_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      n_err++;
    end
  endtask

  // Receiver pacing: random stall bursts, quiet stretches, one long choke.
  initial begin : out_pace
    int hush;
    int cyc;
    bit jitter;
    hush   = 0;
    cyc    = 0;
    jitter = 1'b1;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 100 == 0) jitter = ($urandom_range(0, 3) != 0);
      if (choke_req && rst_n) begin
        // hold off long enough that the pipe fills and in_ready drops
        out_ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
        choke_req = 1'b0;
        hush = 0;
        out_ready <= 1'b1;
      end else if (hush > 0) begin
        out_ready <= 1'b0;
        hush--;
      end else if (!calm && jitter && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        hush = $urandom_range(1, 8) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker: take each accepted word against the oldest expectation.
  initial begin : result_check
    logic took;
    npr_sample_t got_re, got_im;
    logic got_last;
    rot_word_t want;
    forever begin
      @(negedge clk);
      took     = rst_n && (out_valid === 1'b1) && out_ready;
      got_re   = out_re_out;
      got_im   = out_im_out;
      got_last = out_frame_last_out;
      @(posedge clk);
      if (took) begin
        if (rotations_due.size() == 0) begin
          $display("%0t: unexpected word, actual re %0d im %0d last %0b",
                   $time, got_re, got_im, got_last);
          n_err++;
        end else begin
          want = rotations_due.pop_front();
          check_field("re_out", want.re, got_re);
          check_field("im_out", want.im, got_im);
          check_field("frame_last_out", npr_sample_t'(want.last), npr_sample_t'(got_last));
          n_checked++;
        end
      end
    end
  end

  // Stimulus: reset, directed sweep, then random phases at several gains.
  initial begin : stimulus
    logic [31:0] g;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed rows; the first ones run on the reset gain
    for (int r = 0; r < N_PROBES; r++) begin
      if (PROBES[r].gain != gain_now) load_step_gain(PROBES[r].gain);
      offer(PROBES[r].re, PROBES[r].im, PROBES[r].last, PROBES[r].known,
            PROBES[r].k_re, PROBES[r].k_im);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       g = STEP_GAIN_RESET;
        1:       g = 32'd0;
        2:       g = 32'hFFFF_FFFF;
        default: begin
          case ($urandom_range(0, 3))
            0:       g = $urandom;
            1:       g = $urandom_range(0, 65535);
            2:       g = $urandom_range(0, 1023);
            default: g = 32'hFFFF_FFFF - $urandom_range(0, 255);
          endcase
        end
      endcase
      // the gain write also pauses the sender until the pipe runs dry
      load_step_gain(g);
      tx_jitter = ($urandom_range(0, 2) != 0);
      if (ph == CHOKE_PHASE) begin
        // keep offering back to back while the receiver holds off
        tx_jitter = 1'b0;
        choke_req = 1'b1;
      end
      if (ph == N_PHASES - 1) calm = 1'b1;
      for (int k = 0; k < PHASE_WORDS; k++)
        offer(pick_sample(), pick_sample(), ($urandom_range(0, 7) == 0), 1'b0, '0, '0);
    end

    in_valid <= 1'b0;
    while (rotations_due.size() != 0) @(posedge clk);
    // linger a little past the latency to catch any stray word
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Rotated %0d samples under %0d step gain settings, %0d words checked.",
             n_sent, n_settings, n_checked);
    $display("Included zero and full gain, full-scale corners and a long output stall.");
    if (n_err == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    #5_000_000;
    $display("%0t: timeout, %0d words still expected", $time, rotations_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
